[rtl/ascii_frame_checksum_receiver_macros.svh]
// Assertion macros shared by the receiver's modules.
`ifndef ASCII_FRAME_CHECKSUM_RECEIVER_MACROS_SVH
`define ASCII_FRAME_CHECKSUM_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFCR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("afcr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AFCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("afcr assertion failed");

`endif

[rtl/afcr_pkg.sv]
package afcr_pkg;

    localparam int MAX_FRAME   = 8192;
    localparam int COUNT_W     = $clog2(MAX_FRAME + 1);
    localparam int FRAME_LEN_W = 14;
    localparam int SUM_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int TAIL_LEN    = 4;
    // Body bytes start being summed once the checksum window is full.
    localparam int SUM_START   = TAIL_LEN + 1;

    localparam logic [BYTE_W-1:0] SOF_CHAR = 8'h7E;
    localparam logic [BYTE_W-1:0] EOF_CHAR = 8'h0D;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MISMATCH  = 2'd1,
        STATUS_MALFORMED = 2'd2,
        STATUS_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic [SUM_W-1:0]         computed_sum;
        logic [SUM_W-1:0]         received_sum;
        logic [FRAME_LEN_W-1:0]   frame_length;
    } result_t;

    // Returns {invalid, nibble} for one ASCII hex character.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] ch);
        logic [BYTE_W-1:0] diff;
        logic [4:0]        res;
        res = 5'b1_0000;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            diff = ch - 8'h30;
            res  = {1'b0, diff[3:0]};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            diff = ch - 8'h37;
            res  = {1'b0, diff[3:0]};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            diff = ch - 8'h57;
            res  = {1'b0, diff[3:0]};
        end else begin
            diff = '0;
            res  = {1'b1, diff[3:0]};
        end
        return res;
    endfunction

endpackage

[rtl/ascii_frame_checksum_receiver.sv]
// ASCII frame checksum receiver.
// The input channel (s_valid, s_ready, s_rx_byte) carries one received byte per beat.
// Bytes outside a frame are dropped until '~' opens one; '\r' closes it. The last four
// body characters are read as a hex checksum and compared with the two's complement
// of the 16-bit sum of the other body bytes.
// The result channel (m_valid, m_ready, m_frame_status, m_computed_sum,
// m_received_sum, m_frame_length) carries one beat per closed or overflowed frame.
// Throughput: one byte per cycle, sustained, while results are taken.
// A closing byte is held in the input register, then evaluated by the combinational
// frame logic, and its result is loaded into the result register that drives the
// outputs.
// A frame longer than MAX_FRAME bytes reports overflow on the first excess byte,
// which is dropped, and the receiver goes back to hunting for '~'.
// Reset (aresetn low, synchronous) empties both registers and returns to hunting.
// When the result side stalls with a result held, the input register fills and
// s_ready stays low until that result is taken; no beat is lost.
module ascii_frame_checksum_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [afcr_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_frame_status,
    output logic [afcr_pkg::SUM_W-1:0]        m_computed_sum,
    output logic [afcr_pkg::SUM_W-1:0]        m_received_sum,
    output logic [afcr_pkg::FRAME_LEN_W-1:0]  m_frame_length
);
    import afcr_pkg::*;

    logic              advance;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              step;
    logic              res_valid;
    result_t           res;

    assign advance = !m_valid || m_ready;
    assign step    = byte_valid && advance;

    afcr_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    afcr_frame_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    afcr_output_stage u_output (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (res_valid),
        .res            (res),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_frame_status (m_frame_status),
        .m_computed_sum (m_computed_sum),
        .m_received_sum (m_received_sum),
        .m_frame_length (m_frame_length)
    );

endmodule

[rtl/afcr_input_stage.sv]
module afcr_input_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [afcr_pkg::BYTE_W-1:0]    s_rx_byte,
    input  logic                           advance,
    output logic                           byte_valid,
    output logic [afcr_pkg::BYTE_W-1:0]    byte_data
);
    import afcr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // The held beat is consumed whenever the next stage advances.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

[rtl/afcr_frame_tracker.sv]
`include "ascii_frame_checksum_receiver_macros.svh"

module afcr_frame_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [afcr_pkg::BYTE_W-1:0]    byte_data,
    output logic                           res_valid,
    output afcr_pkg::result_t              res
);
    import afcr_pkg::*;

    logic               in_frame_reg;
    logic               in_frame_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   comp_sum;
    logic [BYTE_W-1:0]  tail_reg [TAIL_LEN];
    logic               tail_shift;
    logic [4:0]         hex_dec [TAIL_LEN];
    logic               hex_bad;
    logic [SUM_W-1:0]   hex_value;
    logic               full;

    assign count_inc = count_reg + COUNT_W'(1);
    assign comp_sum  = SUM_W'(~sum_reg + SUM_W'(1));
    assign full      = (count_reg >= COUNT_W'(MAX_FRAME));

    // The oldest character of the window is the most significant digit.
    always_comb begin
        hex_bad   = 1'b0;
        hex_value = '0;
        for (int i = 0; i < TAIL_LEN; i++) begin
            hex_dec[i] = hex_decode(tail_reg[i]);
            hex_bad    = hex_bad | hex_dec[i][4];
            hex_value[SUM_W-1-4*i -: 4] = hex_dec[i][3:0];
        end
    end

    always_comb begin
        in_frame_next    = in_frame_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        tail_shift       = 1'b0;
        res_valid        = 1'b0;
        res.status       = STATUS_OK;
        res.computed_sum = comp_sum;
        res.received_sum = '0;
        res.frame_length = FRAME_LEN_W'(count_inc);
        if (step) begin
            if (!in_frame_reg) begin
                if (byte_data == SOF_CHAR) begin
                    in_frame_next = 1'b1;
                    count_next    = COUNT_W'(1);
                    sum_next      = '0;
                end
            end else if (full) begin
                // The offending byte is dropped, whatever it is.
                res_valid        = 1'b1;
                res.status       = STATUS_OVERFLOW;
                res.computed_sum = '0;
                res.frame_length = FRAME_LEN_W'(count_reg);
                in_frame_next    = 1'b0;
                count_next       = '0;
                sum_next         = '0;
            end else if (byte_data == EOF_CHAR) begin
                res_valid     = 1'b1;
                in_frame_next = 1'b0;
                count_next    = '0;
                sum_next      = '0;
                if (count_reg < COUNT_W'(SUM_START)) begin
                    res.status = STATUS_MALFORMED;
                end else if (hex_bad) begin
                    res.status = STATUS_MALFORMED;
                end else begin
                    res.received_sum = hex_value;
                    res.status = (hex_value == comp_sum) ? STATUS_OK : STATUS_MISMATCH;
                end
            end else begin
                count_next = count_inc;
                tail_shift = 1'b1;
                if (count_reg >= COUNT_W'(SUM_START)) begin
                    sum_next = sum_reg + SUM_W'(tail_reg[0]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tail_shift) begin
            for (int i = 0; i < TAIL_LEN - 1; i++) begin
                tail_reg[i] <= tail_reg[i + 1];
            end
            tail_reg[TAIL_LEN - 1] <= byte_data;
        end
    end

    `AFCR_ASSERT_NOW(a_result_in_frame, aclk, aresetn, res_valid, in_frame_reg && step)
    `AFCR_ASSERT_NEXT(a_result_ends_frame, aclk, aresetn, res_valid, !in_frame_reg && count_reg == '0)
    `AFCR_ASSERT_NOW(a_ok_matches, aclk, aresetn, res_valid && res.status == STATUS_OK,
                     res.received_sum == res.computed_sum)
    `AFCR_ASSERT_NOW(a_count_bound, aclk, aresetn, in_frame_reg,
                     count_reg != '0 && count_reg <= COUNT_W'(MAX_FRAME))

endmodule

[rtl/afcr_output_stage.sv]
`include "ascii_frame_checksum_receiver_macros.svh"

module afcr_output_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  afcr_pkg::result_t                 res,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [1:0]                        m_frame_status,
    output logic [afcr_pkg::SUM_W-1:0]        m_computed_sum,
    output logic [afcr_pkg::SUM_W-1:0]        m_received_sum,
    output logic [afcr_pkg::FRAME_LEN_W-1:0]  m_frame_length
);
    import afcr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_frame_status = res_reg.status;
    assign m_computed_sum = res_reg.computed_sum;
    assign m_received_sum = res_reg.received_sum;
    assign m_frame_length = res_reg.frame_length;

    // A new result may only overwrite a slot that is empty or being taken.
    `AFCR_ASSERT_NOW(a_no_overwrite, aclk, aresetn, load, !valid_reg || m_ready)
    `AFCR_ASSERT_NEXT(a_load_shows, aclk, aresetn, load, valid_reg)
    `AFCR_ASSERT_NEXT(a_hold_unless_taken, aclk, aresetn, valid_reg && !m_ready && !load,
                      valid_reg)

endmodule

[sim/ascii_frame_checksum_receiver_tb.sv]
`timescale 1ns / 1ps

module ascii_frame_checksum_receiver_tb;
    import afcr_pkg::*;

    localparam int RANDOM_BEATS = 1450;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {CHK_GOOD, CHK_WRONG, CHK_NON_HEX} check_kind_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_rx_byte = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [1:0]             m_frame_status;
    logic [SUM_W-1:0]       m_computed_sum;
    logic [SUM_W-1:0]       m_received_sum;
    logic [FRAME_LEN_W-1:0] m_frame_length;

    ascii_frame_checksum_receiver i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_status (m_frame_status),
        .m_computed_sum (m_computed_sum),
        .m_received_sum (m_received_sum),
        .m_frame_length (m_frame_length)
    );

    logic [BYTE_W-1:0] rx_stream[$];
    result_t           frame_verdicts[$];
    result_t           oldest_verdict;

    // Receiver state as predicted from the accepted byte stream.
    bit                rx_in_frame = 1'b0;
    int unsigned       rx_count    = 0;
    logic [SUM_W-1:0]  rx_sum      = '0;
    logic [BYTE_W-1:0] rx_tail[TAIL_LEN] = '{default: '0};

    int unsigned beats_in     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches   = 0;
    int unsigned status_seen[4] = '{default: 0};
    int unsigned phase_mark[2];

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int hex_nibble(input logic [BYTE_W-1:0] ch);
        if (ch >= "0" && ch <= "9") return ch - "0";
        if (ch >= "A" && ch <= "F") return ch - "A" + 10;
        if (ch >= "a" && ch <= "f") return ch - "a" + 10;
        return -1;
    endfunction

    function automatic void stream_add(input logic [BYTE_W-1:0] b);
        rx_stream = {rx_stream, b};
    endfunction

    // Advances the predicted receiver by one accepted byte and queues the
    // verdict when a frame closes or runs past the maximum length.
    function automatic void follow_byte(input logic [BYTE_W-1:0] b);
        result_t     verdict;
        int unsigned body;
        int          nib;
        bit          bad;
        if (!rx_in_frame) begin
            if (b == SOF_CHAR) begin
                rx_in_frame = 1'b1;
                rx_count    = 1;
                rx_sum      = '0;
            end
            return;
        end
        if (rx_count >= MAX_FRAME) begin
            verdict.status       = STATUS_OVERFLOW;
            verdict.computed_sum = '0;
            verdict.received_sum = '0;
            verdict.frame_length = rx_count[FRAME_LEN_W-1:0];
            frame_verdicts = {frame_verdicts, verdict};
            rx_in_frame = 1'b0;
            rx_count    = 0;
            rx_sum      = '0;
            return;
        end
        body = rx_count - 1;
        rx_count++;
        if (b == EOF_CHAR) begin
            verdict.computed_sum = ~rx_sum + 16'd1;
            verdict.received_sum = '0;
            verdict.frame_length = rx_count[FRAME_LEN_W-1:0];
            bad = (body < TAIL_LEN);
            if (!bad) begin
                for (int i = 0; i < TAIL_LEN; i++) begin
                    nib = hex_nibble(rx_tail[i]);
                    if (nib < 0) bad = 1'b1;
                    else verdict.received_sum = {verdict.received_sum[11:0], nib[3:0]};
                end
            end
            if (bad) begin
                verdict.status       = STATUS_MALFORMED;
                verdict.received_sum = '0;
            end else begin
                verdict.status = (verdict.received_sum == verdict.computed_sum) ?
                                 STATUS_OK : STATUS_MISMATCH;
            end
            frame_verdicts = {frame_verdicts, verdict};
            rx_in_frame = 1'b0;
            rx_count    = 0;
            rx_sum      = '0;
            return;
        end
        // The byte leaving the checksum window belongs to the summed body.
        if (body >= TAIL_LEN) rx_sum = rx_sum + rx_tail[0];
        for (int i = 0; i + 1 < TAIL_LEN; i++) rx_tail[i] = rx_tail[i + 1];
        rx_tail[TAIL_LEN - 1] = b;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        if (n < 10) return "0" + n;
        return BYTE_W'(($urandom_range(0, 1) ? "A" : "a") + (n - 10));
    endfunction

    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 15) == 0) return SOF_CHAR;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == EOF_CHAR);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (hex_nibble(b) >= 0 || b == EOF_CHAR);
        return b;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) stream_add(s[i]);
    endfunction

    function automatic void push_frame(input int payload_len, input check_kind_t kind);
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  sent;
        logic [BYTE_W-1:0] b;
        int                pos;
        sum = '0;
        stream_add(SOF_CHAR);
        for (int i = 0; i < payload_len; i++) begin
            b = body_byte();
            sum += b;
            stream_add(b);
        end
        sent = ~sum + 16'd1;
        pos  = $urandom_range(0, 3);
        if (kind == CHK_WRONG) begin
            sent[pos*4 +: 4] = 4'(sent[pos*4 +: 4] + $urandom_range(1, 15));
        end
        for (int i = 3; i >= 0; i--) begin
            if (kind == CHK_NON_HEX && i == pos) stream_add(non_hex_byte());
            else stream_add(hex_char(sent[i*4 +: 4]));
        end
        stream_add(EOF_CHAR);
    endfunction

    function automatic int sender_rest_pct();
        if (beats_in < phase_mark[0]) return 34;
        if (beats_in < phase_mark[1]) return 52;
        return 0;
    endfunction

    function automatic int receiver_rest_pct();
        if (beats_in < phase_mark[0]) return 52;
        if (beats_in < phase_mark[1]) return 34;
        return 0;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Sender: a new beat is offered only once the previous one has gone.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_rx_byte <= '0;
            beats_in  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                follow_byte(s_rx_byte);
                beats_in <= beats_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (rx_stream.size() > 0 && $urandom_range(0, 99) >= sender_rest_pct()) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_stream.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_verdicts.size() == 0) begin
                    $error("unexpected result beat: status %0d, length %0d",
                           m_frame_status, m_frame_length);
                    mismatches++;
                end else begin
                    oldest_verdict = frame_verdicts.pop_front();
                    check_field("frame_status", oldest_verdict.status, m_frame_status);
                    check_field("computed_sum", oldest_verdict.computed_sum, m_computed_sum);
                    check_field("received_sum", oldest_verdict.received_sum, m_received_sum);
                    check_field("frame_length", oldest_verdict.frame_length, m_frame_length);
                    status_seen[oldest_verdict.status]++;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= receiver_rest_pct());
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timed out: no beat moved for %0d cycles.", QUIET_LIMIT);
            $display("ascii_frame_checksum_receiver_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned len;

        // Bytes outside any frame, then empty and short frames, a bad checksum
        // character, and both cases of the hex digits.
        stream_add(8'h00);
        stream_add(8'hFF);
        stream_add(EOF_CHAR);
        push_text("~");
        stream_add(EOF_CHAR);
        push_text("~1~");
        stream_add(EOF_CHAR);
        push_text("~00g0");
        stream_add(EOF_CHAR);
        push_text("~");
        stream_add(8'h01);
        push_text("ffff");
        stream_add(EOF_CHAR);
        push_text("~");
        stream_add(8'hFF);
        push_text("FF02");
        stream_add(EOF_CHAR);

        // Random traffic: mostly well-formed frames, with broken ones and noise.
        while (rx_stream.size() < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
            if (pick < 55) begin
                push_frame(len, CHK_GOOD);
            end else if (pick < 70) begin
                push_frame(len, CHK_WRONG);
            end else if (pick < 80) begin
                push_frame(len, CHK_NON_HEX);
            end else if (pick < 88) begin
                stream_add(SOF_CHAR);
                repeat ($urandom_range(0, 3)) stream_add(body_byte());
                stream_add(EOF_CHAR);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    do len = $urandom_range(0, 255); while (len == SOF_CHAR);
                    stream_add(len[BYTE_W-1:0]);
                end
            end
        end
        phase_mark[0] = rx_stream.size() / 3;
        phase_mark[1] = 2 * rx_stream.size() / 3;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (rx_stream.size() != 0 || s_valid || frame_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d byte beats in three flow-control phases, with noise, short",
                 beats_in);
        $display("and broken frames; verdicts: %0d ok, %0d mismatch, %0d malformed.",
                 status_seen[STATUS_OK], status_seen[STATUS_MISMATCH],
                 status_seen[STATUS_MALFORMED]);
        if (mismatches == 0) begin
            $display("ascii_frame_checksum_receiver_tb: PASS");
        end else begin
            $display("ascii_frame_checksum_receiver_tb: FAIL");
        end
        $finish;
    end

endmodule
